[rtl/dir_pkg.sv]
// ----------------------------------------------------------------------------
// dir_pkg
// Shared constants, types and controller/datapath bundles for the dense id
// renumbering block.
// ----------------------------------------------------------------------------
`default_nettype none

package dir_pkg;

  localparam int FEATURE_SLOTS = 1024;
  localparam int FRAME_SLOTS   = 256;
  localparam int KEY_BITS      = 32;

  localparam int FIELD_KEY_BITS     = 32;
  localparam int DENSE_FEATURE_BITS = 10;
  localparam int DENSE_FRAME_BITS   = 8;

  localparam int KEY_W = (KEY_BITS < FIELD_KEY_BITS) ? KEY_BITS : FIELD_KEY_BITS;

  localparam int FEAT_AW = $clog2(FEATURE_SLOTS);
  localparam int FRAME_AW = $clog2(FRAME_SLOTS);
  localparam int FEAT_CW = $clog2(FEATURE_SLOTS + 1);
  localparam int FRAME_CW = $clog2(FRAME_SLOTS + 1);

  localparam int MAX_SLOTS = (FEATURE_SLOTS > FRAME_SLOTS) ? FEATURE_SLOTS : FRAME_SLOTS;
  localparam int SCAN_W = $clog2(MAX_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } dir_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } dir_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dir_sts_t;

endpackage

`default_nettype wire

[rtl/dir_if.sv]
// ----------------------------------------------------------------------------
// dir_if
// Valid/ready channels for observation requests and dense number results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dir_in_if import dir_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [FIELD_KEY_BITS-1:0] feature_key;
  logic [FIELD_KEY_BITS-1:0] frame_key;

  modport source (output valid, output feature_key, output frame_key, input ready);
  modport sink   (input valid, input feature_key, input frame_key, output ready);
endinterface

interface dir_out_if import dir_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic [DENSE_FEATURE_BITS-1:0] dense_feature;
  logic [DENSE_FRAME_BITS-1:0]   dense_frame;
  logic                          feature_overflow;
  logic                          frame_overflow;

  modport source (output valid, output dense_feature, output dense_frame,
                  output feature_overflow, output frame_overflow, input ready);
  modport sink   (input valid, input dense_feature, input dense_frame,
                  input feature_overflow, input frame_overflow, output ready);
endinterface

`default_nettype wire

[rtl/dense_id_renumbering.sv]
// ----------------------------------------------------------------------------
// dense_id_renumbering
// First-seen id compaction: maps sparse feature and frame keys to dense
// numbers in order of first appearance.
//
// obs channel: one request per observation (feature_key, frame_key).
// dense channel: one result per request (dense_feature, dense_frame and
// two overflow flags). Both are valid/ready, transfer on valid && ready.
// One request is in work at a time. After acceptance the block scans both
// key tables in parallel, one stored entry per cycle from block RAM with
// registered read. The scan runs over the entries of the larger table; then
// the result is committed to the output register and the block returns to
// idle to take the next request, so a new request is not taken until the
// previous one is committed. The scan loop over the larger table sets the rate.
// The result sits in an output register; the next request is taken while
// it waits. If the receiver stalls, a finished scan holds in its commit
// step until the output register frees up. Reset empties both tables at
// once (counts go to zero); no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_id_renumbering import dir_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  dir_in_if.sink   obs,
  dir_out_if.source dense
);

  dir_cmd_t cmd;
  dir_sts_t sts;

  dir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (obs.valid),
    .req_ready (obs.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dir_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .feature_key      (obs.feature_key),
    .frame_key        (obs.frame_key),
    .out_valid        (dense.valid),
    .out_ready        (dense.ready),
    .dense_feature    (dense.dense_feature),
    .dense_frame      (dense.dense_frame),
    .feature_overflow (dense.feature_overflow),
    .frame_overflow   (dense.frame_overflow)
  );

endmodule

`default_nettype wire

[rtl/dir_ram.sv]
// ----------------------------------------------------------------------------
// dir_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/dir_ctrl.sv]
// ----------------------------------------------------------------------------
// dir_ctrl
// Sequencer: accept a request, run the table scan, commit the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dir_ctrl import dir_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire dir_sts_t sts,
  output dir_cmd_t      cmd
);

  dir_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/dir_datapath.sv]
// ----------------------------------------------------------------------------
// dir_datapath
// Key tables, entry counts, scan counter, match logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dir_datapath import dir_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dir_cmd_t                      cmd,
  output dir_sts_t                           sts,
  input  wire logic [FIELD_KEY_BITS-1:0]     feature_key,
  input  wire logic [FIELD_KEY_BITS-1:0]     frame_key,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [DENSE_FEATURE_BITS-1:0] dense_feature,
  output logic      [DENSE_FRAME_BITS-1:0]   dense_frame,
  output logic                               feature_overflow,
  output logic                               frame_overflow
);

  logic [KEY_W-1:0]    fkey, ckey;
  logic [FEAT_CW-1:0]  fcount;
  logic [FRAME_CW-1:0] ccount;
  logic [SCAN_W-1:0]   scan_idx, scan_idx_q;
  logic                fpend, cpend;
  logic                ffound, cfound;
  logic [FEAT_AW-1:0]  fhit;
  logic [FRAME_AW-1:0] chit;
  logic [KEY_W-1:0]    frdata, crdata;
  logic                fmore, cmore;
  logic                ffull, cfull;
  logic                fwe, cwe;
  logic [FEAT_AW-1:0]  fnum;
  logic [FRAME_AW-1:0] cnum;

  assign fmore = scan_idx < SCAN_W'(fcount);
  assign cmore = scan_idx < SCAN_W'(ccount);
  assign ffull = fcount == FEAT_CW'(FEATURE_SLOTS);
  assign cfull = ccount == FRAME_CW'(FRAME_SLOTS);

  assign sts.scan_done = !fmore && !cmore && !fpend && !cpend;
  assign sts.out_free  = !out_valid || out_ready;

  assign fwe = cmd.commit && !ffound && !ffull;
  assign cwe = cmd.commit && !cfound && !cfull;

  // number committed for each table
  assign fnum = ffound ? fhit : (ffull ? '0 : fcount[FEAT_AW-1:0]);
  assign cnum = cfound ? chit : (cfull ? '0 : ccount[FRAME_AW-1:0]);

  dir_ram #(.WIDTH(KEY_W), .DEPTH(FEATURE_SLOTS)) u_feat_ram (
    .clk   (clk),
    .we    (fwe),
    .waddr (fcount[FEAT_AW-1:0]),
    .wdata (fkey),
    .raddr (scan_idx[FEAT_AW-1:0]),
    .rdata (frdata)
  );

  dir_ram #(.WIDTH(KEY_W), .DEPTH(FRAME_SLOTS)) u_frame_ram (
    .clk   (clk),
    .we    (cwe),
    .waddr (ccount[FRAME_AW-1:0]),
    .wdata (ckey),
    .raddr (scan_idx[FRAME_AW-1:0]),
    .rdata (crdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount    <= '0;
      ccount    <= '0;
      fpend     <= 1'b0;
      cpend     <= 1'b0;
      ffound    <= 1'b0;
      cfound    <= 1'b0;
      scan_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx <= '0;
        fpend    <= 1'b0;
        cpend    <= 1'b0;
        ffound   <= 1'b0;
        cfound   <= 1'b0;
      end else begin
        if (cmd.scan) begin
          fpend <= fmore;
          cpend <= cmore;
          if (fmore || cmore) begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        // compare registered read data of the previous address
        if (fpend && !ffound && frdata == fkey) begin
          ffound <= 1'b1;
        end
        if (cpend && !cfound && crdata == ckey) begin
          cfound <= 1'b1;
        end
      end
      if (fwe) begin
        fcount <= fcount + 1'b1;
      end
      if (cwe) begin
        ccount <= ccount + 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fkey <= feature_key[KEY_W-1:0];
      ckey <= frame_key[KEY_W-1:0];
    end
    if (cmd.scan) begin
      scan_idx_q <= scan_idx;
    end
    if (fpend && !ffound && frdata == fkey) begin
      fhit <= scan_idx_q[FEAT_AW-1:0];
    end
    if (cpend && !cfound && crdata == ckey) begin
      chit <= scan_idx_q[FRAME_AW-1:0];
    end
    if (cmd.commit) begin
      dense_feature    <= DENSE_FEATURE_BITS'(fnum);
      dense_frame      <= DENSE_FRAME_BITS'(cnum);
      feature_overflow <= !ffound && ffull;
      frame_overflow   <= !cfound && cfull;
    end
  end

endmodule

`default_nettype wire

[rtl/dir_checker.sv]
// ----------------------------------------------------------------------------
// dir_checker
// Port-level checks for the dense id renumbering block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dir_checker import dir_pkg::*; (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          obs_valid,
  input wire logic                          obs_ready,
  input wire logic                          dense_valid,
  input wire logic                          dense_ready,
  input wire logic [DENSE_FEATURE_BITS-1:0] dense_feature,
  input wire logic [DENSE_FRAME_BITS-1:0]   dense_frame,
  input wire logic                          feature_overflow,
  input wire logic                          frame_overflow
);

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    obs_valid && obs_ready |=> !obs_ready)
    else $error("request taken while another is in work");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    obs_valid && obs_ready && !dense_valid |=> !dense_valid)
    else $error("result appeared the cycle after a request");

  a_feat_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    dense_valid && feature_overflow |-> dense_feature == '0)
    else $error("feature overflow with nonzero number");

  a_frame_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    dense_valid && frame_overflow |-> dense_frame == '0)
    else $error("frame overflow with nonzero number");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    dense_valid && !dense_ready |=> dense_valid)
    else $error("result dropped while stalled");

endmodule

bind dense_id_renumbering dir_checker u_dir_checker (
  .clk              (clk),
  .rst              (rst),
  .obs_valid        (obs.valid),
  .obs_ready        (obs.ready),
  .dense_valid      (dense.valid),
  .dense_ready      (dense.ready),
  .dense_feature    (dense.dense_feature),
  .dense_frame      (dense.dense_frame),
  .feature_overflow (dense.feature_overflow),
  .frame_overflow   (dense.frame_overflow)
);

`default_nettype wire
